### sv/cmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_pkg
// Shared constants and types for the complex magnitude clipper datapath.
// ----------------------------------------------------------------------------
package cmc_pkg;

    // fractional guard bits carried through the CORDIC datapath
    localparam int GUARD_BITS       = 8;
    // reciprocal of the CORDIC gain, 0.6072529 scaled by 2^16
    localparam int INV_GAIN         = 39797;
    localparam int INV_GAIN_BITS    = 16;
    // clip level after reset
    localparam int CLIP_LEVEL_RESET = 32767;

    // per-stage control that travels with each sample
    typedef struct packed {
        logic valid;
        logic flip;   // sample was mirrored out of the left half plane
    } cmc_ctrl_t;

endpackage

### sv/cmc_cordic_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_cordic_step
// One registered CORDIC iteration: a vectoring micro-rotation on the sample
// and, steered by the same direction, the inverse micro-rotation on the
// rebuild vector. The original sample rides along for the pass-through case.
// ----------------------------------------------------------------------------
module cmc_cordic_step import cmc_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int DATA_W      = 27,
    parameter int SHIFT       = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  cmc_ctrl_t                     ctrl_in,
    input  logic signed [DATA_W-1:0]      vx_in,
    input  logic signed [DATA_W-1:0]      vy_in,
    input  logic signed [DATA_W-1:0]      rx_in,
    input  logic signed [DATA_W-1:0]      ry_in,
    input  logic signed [SAMPLE_BITS-1:0] i_in,
    input  logic signed [SAMPLE_BITS-1:0] q_in,
    output cmc_ctrl_t                     ctrl_out,
    output logic signed [DATA_W-1:0]      vx_out,
    output logic signed [DATA_W-1:0]      vy_out,
    output logic signed [DATA_W-1:0]      rx_out,
    output logic signed [DATA_W-1:0]      ry_out,
    output logic signed [SAMPLE_BITS-1:0] i_out,
    output logic signed [SAMPLE_BITS-1:0] q_out
);

    cmc_ctrl_t                     ctrl_reg;
    logic signed [DATA_W-1:0]      vx_reg, vy_reg, rx_reg, ry_reg;
    logic signed [DATA_W-1:0]      vx_next, vy_next, rx_next, ry_next;
    logic signed [SAMPLE_BITS-1:0] i_reg, q_reg;
    logic signed [DATA_W-1:0]      vx_sh, vy_sh, rx_sh, ry_sh;
    logic                          dir;

    assign vx_sh = vx_in >>> SHIFT;
    assign vy_sh = vy_in >>> SHIFT;
    assign rx_sh = rx_in >>> SHIFT;
    assign ry_sh = ry_in >>> SHIFT;

    // rotate clockwise while y is non-negative; rebuild turns the other way
    assign dir = ~vy_in[DATA_W-1];

    always_comb begin
        if (dir) begin
            vx_next = vx_in + vy_sh;
            vy_next = vy_in - vx_sh;
            rx_next = rx_in - ry_sh;
            ry_next = ry_in + rx_sh;
        end else begin
            vx_next = vx_in - vy_sh;
            vy_next = vy_in + vx_sh;
            rx_next = rx_in + ry_sh;
            ry_next = ry_in - rx_sh;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            i_reg  <= i_in;
            q_reg  <= q_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign vx_out   = vx_reg;
    assign vy_out   = vy_reg;
    assign rx_out   = rx_reg;
    assign ry_out   = ry_reg;
    assign i_out    = i_reg;
    assign q_out    = q_reg;

endmodule

### sv/complex_magnitude_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_magnitude_clipper
// Limits the envelope of a complex I/Q stream to a programmable clip level,
// keeping the phase of each sample.
// ----------------------------------------------------------------------------
// Accepts one I/Q sample per clock while the output is not stalled and
// returns one sample per input, in order. The pipeline is an input register,
// one register per CORDIC iteration, a gain-compensation multiply stage and
// the output register. The vectoring CORDIC (magnitude) and the rotating
// CORDIC (rebuild on the clip circle) run side by side in the same stages, so
// the stage count alone sets the latency. The whole pipeline holds while the
// output is stalled; s_ready follows !m_valid || m_ready. Samples whose
// magnitude is at most clip_level pass unchanged; larger ones come out on
// the clip circle, rounded to nearest and saturated. Write clip_level
// (cfg_wdata, always ready) only while no sample is in flight.
// ----------------------------------------------------------------------------
module complex_magnitude_clipper import cmc_pkg::*; #(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // clip level write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [SAMPLE_BITS-1:0]        cfg_wdata,
    // sample in
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_i_in,
    input  logic signed [SAMPLE_BITS-1:0] s_q_in,
    // sample out
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_i_out,
    output logic signed [SAMPLE_BITS-1:0] m_q_out
);

    localparam int W      = SAMPLE_BITS + GUARD_BITS + 3;
    localparam int LW     = W + INV_GAIN_BITS + 1;
    localparam int PW     = SAMPLE_BITS + INV_GAIN_BITS + GUARD_BITS + 1;
    localparam int NSTAGE = CORDIC_STAGES;
    localparam logic [SAMPLE_BITS-1:0] CLIP_RESET = SAMPLE_BITS'(CLIP_LEVEL_RESET);
    localparam logic signed [W:0] SAT_HI = (W+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [W:0] SAT_LO = -SAT_HI - (W+1)'(1);

    // start radius of the rebuild rotation: level * 2^8 * INV_GAIN / 2^16, rounded
    function automatic logic signed [W-1:0] radius(input logic [SAMPLE_BITS-1:0] lvl);
        logic [PW-1:0] acc;
        acc = ((PW'(lvl) * PW'(INV_GAIN)) << GUARD_BITS)
              + PW'(1 << (INV_GAIN_BITS - 1));
        return W'(acc >> INV_GAIN_BITS);
    endfunction

    // drop guard bits with round half up, then saturate
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic signed [W-1:0] v);
        logic signed [W:0] t;
        t = ((W+1)'(v) + (W+1)'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
        if (t > SAT_HI) begin
            return SAMPLE_BITS'(SAT_HI);
        end else if (t < SAT_LO) begin
            return SAMPLE_BITS'(SAT_LO);
        end else begin
            return SAMPLE_BITS'(t);
        end
    endfunction

    // ---------------- configuration ----------------
    logic [SAMPLE_BITS-1:0] clip_reg;
    logic signed [W-1:0]    radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_reg   <= CLIP_RESET;
            radius_reg <= radius(CLIP_RESET);
        end else if (cfg_valid) begin
            clip_reg   <= cfg_wdata;
            radius_reg <= radius(cfg_wdata);
        end
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic m_valid_reg;

    assign en      = ~m_valid_reg | m_ready;
    assign s_ready = en;

    // ---------------- input stage ----------------
    cmc_ctrl_t                     ctrl0_reg;
    logic signed [W-1:0]           vx0_reg, vy0_reg;
    logic signed [SAMPLE_BITS-1:0] i0_reg, q0_reg;
    logic signed [W-1:0]           i_ext, q_ext;
    logic                          flip;

    assign i_ext = W'(s_i_in);
    assign q_ext = W'(s_q_in);
    assign flip  = s_i_in[SAMPLE_BITS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl0_reg <= '0;
        end else if (en) begin
            ctrl0_reg.valid <= s_valid;
            ctrl0_reg.flip  <= flip;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx0_reg <= (flip ? -i_ext : i_ext) <<< GUARD_BITS;
            vy0_reg <= (flip ? -q_ext : q_ext) <<< GUARD_BITS;
            i0_reg  <= s_i_in;
            q0_reg  <= s_q_in;
        end
    end

    // ---------------- CORDIC stages ----------------
    cmc_ctrl_t                     ctrl_pipe [NSTAGE+1];
    logic signed [W-1:0]           vx_pipe   [NSTAGE+1];
    logic signed [W-1:0]           vy_pipe   [NSTAGE+1];
    logic signed [W-1:0]           rx_pipe   [NSTAGE+1];
    logic signed [W-1:0]           ry_pipe   [NSTAGE+1];
    logic signed [SAMPLE_BITS-1:0] i_pipe    [NSTAGE+1];
    logic signed [SAMPLE_BITS-1:0] q_pipe    [NSTAGE+1];

    assign ctrl_pipe[0] = ctrl0_reg;
    assign vx_pipe[0]   = vx0_reg;
    assign vy_pipe[0]   = vy0_reg;
    assign rx_pipe[0]   = radius_reg;   // user keeps clip level static while samples flow; not enforced here
    assign ry_pipe[0]   = '0;
    assign i_pipe[0]    = i0_reg;
    assign q_pipe[0]    = q0_reg;

    for (genvar k = 0; k < NSTAGE; k++) begin : g_step
        cmc_cordic_step #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .DATA_W      (W),
            .SHIFT       (k)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctrl_in  (ctrl_pipe[k]),
            .vx_in    (vx_pipe[k]),
            .vy_in    (vy_pipe[k]),
            .rx_in    (rx_pipe[k]),
            .ry_in    (ry_pipe[k]),
            .i_in     (i_pipe[k]),
            .q_in     (q_pipe[k]),
            .ctrl_out (ctrl_pipe[k+1]),
            .vx_out   (vx_pipe[k+1]),
            .vy_out   (vy_pipe[k+1]),
            .rx_out   (rx_pipe[k+1]),
            .ry_out   (ry_pipe[k+1]),
            .i_out    (i_pipe[k+1]),
            .q_out    (q_pipe[k+1])
        );
    end

    // ---------------- gain compensation / rounding stage ----------------
    logic                          mul_valid_reg;
    logic signed [LW-1:0]          lhs_reg;
    logic signed [SAMPLE_BITS-1:0] fi_reg, fq_reg;
    logic signed [SAMPLE_BITS-1:0] pi_reg, pq_reg;
    logic signed [W-1:0]           rx_end, ry_end;

    assign rx_end = ctrl_pipe[NSTAGE].flip ? -rx_pipe[NSTAGE] : rx_pipe[NSTAGE];
    assign ry_end = ctrl_pipe[NSTAGE].flip ? -ry_pipe[NSTAGE] : ry_pipe[NSTAGE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= ctrl_pipe[NSTAGE].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lhs_reg <= LW'(vx_pipe[NSTAGE]) * LW'(INV_GAIN);
            fi_reg  <= round_sat(rx_end);
            fq_reg  <= round_sat(ry_end);
            pi_reg  <= i_pipe[NSTAGE];
            pq_reg  <= q_pipe[NSTAGE];
        end
    end

    // ---------------- compare / output stage ----------------
    logic signed [LW-1:0]          rhs;
    logic                          clipped;
    logic signed [SAMPLE_BITS-1:0] m_i_out_reg, m_q_out_reg;

    assign rhs     = $signed(LW'(clip_reg) << (GUARD_BITS + INV_GAIN_BITS));
    assign clipped = lhs_reg > rhs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_i_out_reg <= clipped ? fi_reg : pi_reg;
            m_q_out_reg <= clipped ? fq_reg : pq_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_i_out = m_i_out_reg;
    assign m_q_out = m_q_out_reg;

    // ---------------- assertions ----------------
    // vectoring leaves x on the non-negative real axis
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_pipe[NSTAGE].valid |-> !vx_pipe[NSTAGE][W-1])
        else $error("vectoring magnitude went negative");

    // a zero sample has zero magnitude and can never be clipped
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_valid_reg && pi_reg == '0 && pq_reg == '0 |-> lhs_reg == '0)
        else $error("zero sample produced nonzero magnitude");

    // zero clip level rebuilds onto the origin
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_valid_reg && clip_reg == '0 |-> fi_reg == '0 && fq_reg == '0)
        else $error("zero clip level gave nonzero rebuild");

    // a stall freezes the pipeline tail
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(mul_valid_reg) && $stable(lhs_reg) && $stable(fi_reg))
        else $error("pipeline advanced during stall");

endmodule
